// File: rtl/quaternion_to_euler_angles_core_macros.svh
// Assertion helpers, included by quaternion_to_euler_angles_core.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// Checked only out of reset.
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/q2e_pkg.sv
package q2e_pkg;

  localparam int QW         = 16;
  localparam int PRODW      = 32;
  localparam int OPW        = 34;
  localparam int ANGW       = 16;
  localparam int PMW        = 30;
  localparam int SQW        = 59;
  localparam int ROOTW      = 29;
  localparam int MAX_STAGES = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_NEG  = 2'd1,
    LOCK_POS  = 2'd2
  } lock_t;

  typedef struct packed {
    logic signed [OPW-1:0] ya;
    logic signed [OPW-1:0] yb;
    logic signed [OPW-1:0] ra;
    logic signed [OPW-1:0] rb;
    logic signed [PMW-1:0] pm;
    lock_t                 lock;
  } side_t;

  // atan(2^-i), 2^-32 turn
  localparam logic [31:0] ATAN_TAB [0:MAX_STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// File: rtl/quaternion_to_euler_angles_core.sv
// Channel   Handshake              Payload
// in_       in_valid / in_ready    in_quat_x, in_quat_y, in_quat_z, in_quat_w
// out_      out_valid / out_ready  out_yaw_angle, out_pitch_angle, out_roll_angle,
//                                  out_lock_case
// One quaternion per cycle while the output does not stall the pipeline.
// The pipeline depth is set by the 29-stage square root and the unrolled CORDIC.
// Reset clears only the valid bits of each stage.
// When out_valid is high and out_ready low, the whole pipeline holds.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_quat_x,
  input  logic signed [15:0]  in_quat_y,
  input  logic signed [15:0]  in_quat_z,
  input  logic signed [15:0]  in_quat_w,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_yaw_angle,
  output logic signed [15:0]  out_pitch_angle,
  output logic signed [15:0]  out_roll_angle,
  output logic [1:0]          out_lock_case
);
  import q2e_pkg::*;

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: products
  logic                   v1_r;
  logic signed [PRODW-1:0] xy_r, wz_r, yy_r, zz_r, yz_r, wx_r, xx_r, wy_r, xz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy_r <= in_quat_x * in_quat_y;
      wz_r <= in_quat_w * in_quat_z;
      yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      yz_r <= in_quat_y * in_quat_z;
      wx_r <= in_quat_w * in_quat_x;
      xx_r <= in_quat_x * in_quat_x;
      wy_r <= in_quat_w * in_quat_y;
      xz_r <= in_quat_x * in_quat_z;
    end
  end

  // stage 2: operand sums and branch
  logic signed [OPW-1:0] one_w;
  logic signed [32:0]    p_w;
  logic signed [OPW-1:0] ya_w, yb_w, ra_w, rb_w, la_w, lb_w;
  lock_t                 lock_w;
  logic                  v2_r;
  side_t                 s2_r;

  assign one_w = OPW'(1) <<< 30;

  always_comb begin
    p_w  = 33'(wy_r) - 33'(xz_r);
    ya_w = (OPW'(xy_r) + OPW'(wz_r)) <<< 1;
    yb_w = one_w - ((OPW'(yy_r) + OPW'(zz_r)) <<< 1);
    ra_w = (OPW'(yz_r) + OPW'(wx_r)) <<< 1;
    rb_w = one_w - ((OPW'(xx_r) + OPW'(yy_r)) <<< 1);
    la_w = (OPW'(xy_r) - OPW'(wz_r)) <<< 1;
    lb_w = one_w - ((OPW'(xx_r) + OPW'(zz_r)) <<< 1);
    if (p_w >= (33'sd1 <<< 29)) begin
      lock_w = LOCK_POS;
    end else if (p_w <= -(33'sd1 <<< 29)) begin
      lock_w = LOCK_NEG;
    end else begin
      lock_w = LOCK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.ya   <= ya_w;
      s2_r.yb   <= yb_w;
      s2_r.ra   <= (lock_w == LOCK_NONE) ? ra_w : la_w;
      s2_r.rb   <= (lock_w == LOCK_NONE) ? rb_w : lb_w;
      s2_r.pm   <= (lock_w == LOCK_NONE) ? p_w[PMW-1:0] : '0;
      s2_r.lock <= lock_w;
    end
  end

  // stage 3: cosine squared, 2^58 - p^2
  logic signed [2*PMW-1:0] pp_w;
  logic [SQW-1:0]          rem_r  [0:ROOTW];
  logic [ROOTW-1:0]        root_r [0:ROOTW];
  side_t                   sd_r   [0:ROOTW];
  logic                    vs_r   [0:ROOTW];

  assign pp_w = s2_r.pm * s2_r.pm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (en) begin
      vs_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= (SQW'(1) << 58) - pp_w[SQW-1:0];
      root_r[0] <= '0;
      sd_r[0]   <= s2_r;
    end
  end

  // square root, one bit per stage
  for (genvar j = 1; j <= ROOTW; j++) begin : g_sqrt
    localparam int KB = ROOTW - j;
    logic [SQW-1:0] t_w;
    assign t_w = (SQW'(root_r[j-1]) << (KB + 1)) | (SQW'(1) << (2 * KB));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[j] <= 1'b0;
      end else if (en) begin
        vs_r[j] <= vs_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[j] <= sd_r[j-1];
        if (rem_r[j-1] >= t_w) begin
          rem_r[j]  <= rem_r[j-1] - t_w;
          root_r[j] <= root_r[j-1] | (ROOTW'(1) << KB);
        end else begin
          rem_r[j]  <= rem_r[j-1];
          root_r[j] <= root_r[j-1];
        end
      end
    end
  end

  // three angle units
  side_t                 sq_w;
  logic signed [OPW-1:0] pa_w;
  logic signed [OPW-1:0] pb_w;
  logic                  vp_w, vy_w, vr_w;
  logic [ANGW-1:0]       yaw_w, pit_w, rol_w;
  logic [1:0]            tag_w, ty_w, tr_w;

  assign sq_w = sd_r[ROOTW];
  assign pa_w = OPW'(sq_w.pm);
  assign pb_w = OPW'(root_r[ROOTW]);

  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(vs_r[ROOTW]), .in_a(pa_w), .in_b(pb_w), .in_tag(sq_w.lock),
    .out_vld(vp_w), .out_angle(pit_w), .out_tag(tag_w)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(vs_r[ROOTW]), .in_a(sq_w.ya), .in_b(sq_w.yb), .in_tag(sq_w.lock),
    .out_vld(vy_w), .out_angle(yaw_w), .out_tag(ty_w)
  );

  q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(vs_r[ROOTW]), .in_a(sq_w.ra), .in_b(sq_w.rb), .in_tag(sq_w.lock),
    .out_vld(vr_w), .out_angle(rol_w), .out_tag(tr_w)
  );

  // output register
  logic [ANGW-1:0] yaw_nxt, pit_nxt, rol_nxt;
  logic [ANGW-1:0] yaw_r, pit_r, rol_r;
  logic [1:0]      lock_r;

  always_comb begin
    unique case (tag_w)
      LOCK_POS: begin
        yaw_nxt = '0;
        pit_nxt = 16'sd16384;
        rol_nxt = rol_w;
      end
      LOCK_NEG: begin
        yaw_nxt = '0;
        pit_nxt = -16'sd16384;
        rol_nxt = -rol_w;
      end
      default: begin
        yaw_nxt = yaw_w;
        pit_nxt = pit_w;
        rol_nxt = rol_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vp_w && vy_w && vr_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r  <= yaw_nxt;
      pit_r  <= pit_nxt;
      rol_r  <= rol_nxt;
      lock_r <= tag_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_yaw_angle   = yaw_r;
  assign out_pitch_angle = pit_r;
  assign out_roll_angle  = rol_r;
  assign out_lock_case   = lock_r;

`include "quaternion_to_euler_angles_core_macros.svh"

  `Q2E_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid_r, "valid set after reset")
  `Q2E_ASSERT(a_lock_yaw, (out_valid_r && lock_r != LOCK_NONE) |-> (yaw_r == '0), "lock yaw")
  `Q2E_ASSERT(a_lock_pos, (out_valid_r && lock_r == LOCK_POS) |-> (pit_r == 16'd16384), "pitch")
  `Q2E_ASSERT(a_lanes_sync, (vp_w == vy_w) && (vp_w == vr_w), "angle units out of step")
  `Q2E_ASSERT(a_hold, !en |=> $stable(yaw_r) && $stable(lock_r), "result moved while stalled")

endmodule

// File: rtl/q2e_atan2.sv
module q2e_atan2 #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [33:0]       in_a,
  input  logic signed [33:0]       in_b,
  input  logic [1:0]               in_tag,
  output logic                     out_vld,
  output logic [15:0]              out_angle,
  output logic [1:0]               out_tag
);
  import q2e_pkg::*;

  localparam int NW = 42;
  localparam int MW = 41;
  localparam int XW = 45;
  localparam int ZW = 34;
  localparam int NN = 6;

  logic                 n_v_r    [0:NN];
  logic                 n_zero_r [0:NN];
  logic                 n_negb_r [0:NN];
  logic [1:0]           n_tag_r  [0:NN];
  logic signed [NW-1:0] n_a_r    [0:NN];
  logic signed [NW-1:0] n_b_r    [0:NN];
  logic [MW-1:0]        n_mx_r   [0:NN];

  logic                 i_v_r    [0:STAGES];
  logic                 i_zero_r [0:STAGES];
  logic                 i_negb_r [0:STAGES];
  logic [1:0]           i_tag_r  [0:STAGES];
  logic signed [XW-1:0] i_x_r    [0:STAGES];
  logic signed [XW-1:0] i_y_r    [0:STAGES];
  logic signed [ZW-1:0] i_z_r    [0:STAGES];

  logic                 o_v_r;
  logic [ANGW-1:0]      o_ang_r;
  logic [1:0]           o_tag_r;

  logic signed [OPW:0]  ma_w;
  logic signed [OPW:0]  mb_w;
  logic [MW-1:0]        mx_w;

  always_comb begin
    ma_w = (in_a < 0) ? -(35'(in_a)) : 35'(in_a);
    mb_w = (in_b < 0) ? -(35'(in_b)) : 35'(in_b);
    mx_w = (ma_w > mb_w) ? MW'(ma_w[OPW-1:0]) : MW'(mb_w[OPW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r[0] <= 1'b0;
    end else if (en) begin
      n_v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_zero_r[0] <= (in_a == '0);
      n_negb_r[0] <= (in_b < 0);
      n_tag_r[0]  <= in_tag;
      n_a_r[0]    <= NW'(in_a);
      n_b_r[0]    <= NW'(in_b);
      n_mx_r[0]   <= mx_w;
    end
  end

  for (genvar j = 1; j <= NN; j++) begin : g_norm
    localparam int S = 64 >> j;
    logic sh_w;
    assign sh_w = (n_mx_r[j-1] < (MW'(1) << (MW - S)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        n_v_r[j] <= 1'b0;
      end else if (en) begin
        n_v_r[j] <= n_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_zero_r[j] <= n_zero_r[j-1];
        n_negb_r[j] <= n_negb_r[j-1];
        n_tag_r[j]  <= n_tag_r[j-1];
        n_a_r[j]    <= sh_w ? (n_a_r[j-1] <<< S) : n_a_r[j-1];
        n_b_r[j]    <= sh_w ? (n_b_r[j-1] <<< S) : n_b_r[j-1];
        n_mx_r[j]   <= sh_w ? (n_mx_r[j-1] << S) : n_mx_r[j-1];
      end
    end
  end

  logic signed [XW-1:0] a0_w;
  logic signed [XW-1:0] b0_w;
  assign a0_w = XW'(n_a_r[NN]);
  assign b0_w = XW'(n_b_r[NN]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r[0] <= 1'b0;
    end else if (en) begin
      i_v_r[0] <= n_v_r[NN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_zero_r[0] <= n_zero_r[NN];
      i_negb_r[0] <= n_negb_r[NN];
      i_tag_r[0]  <= n_tag_r[NN];
      if (b0_w < 0) begin
        if (a0_w >= 0) begin
          i_x_r[0] <= a0_w;
          i_y_r[0] <= -b0_w;
          i_z_r[0] <= ZW'(1) <<< 30;
        end else begin
          i_x_r[0] <= -a0_w;
          i_y_r[0] <= b0_w;
          i_z_r[0] <= -(ZW'(1) <<< 30);
        end
      end else begin
        i_x_r[0] <= b0_w;
        i_y_r[0] <= a0_w;
        i_z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [XW-1:0] sx_w;
    logic signed [XW-1:0] sy_w;
    logic signed [ZW-1:0] at_w;
    assign sx_w = i_x_r[i] >>> i;
    assign sy_w = i_y_r[i] >>> i;
    assign at_w = ZW'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        i_v_r[i+1] <= 1'b0;
      end else if (en) begin
        i_v_r[i+1] <= i_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        i_zero_r[i+1] <= i_zero_r[i];
        i_negb_r[i+1] <= i_negb_r[i];
        i_tag_r[i+1]  <= i_tag_r[i];
        if (i_y_r[i] > 0) begin
          i_x_r[i+1] <= i_x_r[i] + sy_w;
          i_y_r[i+1] <= i_y_r[i] - sx_w;
          i_z_r[i+1] <= i_z_r[i] + at_w;
        end else begin
          i_x_r[i+1] <= i_x_r[i] - sy_w;
          i_y_r[i+1] <= i_y_r[i] + sx_w;
          i_z_r[i+1] <= i_z_r[i] - at_w;
        end
      end
    end
  end

  logic signed [ZW-1:0] zr_w;
  assign zr_w = i_z_r[STAGES] + ZW'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= i_v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_tag_r <= i_tag_r[STAGES];
      if (i_zero_r[STAGES]) begin
        o_ang_r <= i_negb_r[STAGES] ? 16'h8000 : 16'h0000;
      end else begin
        o_ang_r <= zr_w[31:16];
      end
    end
  end

  assign out_vld   = o_v_r;
  assign out_angle = o_ang_r;
  assign out_tag   = o_tag_r;

endmodule
